/* design/rvde_pkg.sv */
// Shared types, encodings and widths for the RV32I decode and execute block.
`default_nettype none

package rvde_pkg;

    // Stream widths
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 152;
    localparam int M_TUSER_W = 2;

    // Queue between front and back (depth must be a power of two)
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Marker word that ends a program: ADDI x10,x0,255
    localparam logic [31:0] HALT_WORD = 32'h0ff00513;

    // Major opcodes
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;

    // funct7 values
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    // funct3 values
    localparam logic [2:0] F3_JALR   = 3'd0;
    localparam logic [2:0] F3_BYTE   = 3'd0;
    localparam logic [2:0] F3_HALF   = 3'd1;
    localparam logic [2:0] F3_WORD   = 3'd2;
    localparam logic [2:0] F3_BYTE_U = 3'd4;
    localparam logic [2:0] F3_HALF_U = 3'd5;
    localparam logic [2:0] F3_ADD    = 3'd0;
    localparam logic [2:0] F3_SLL    = 3'd1;
    localparam logic [2:0] F3_SLT    = 3'd2;
    localparam logic [2:0] F3_SLTU   = 3'd3;
    localparam logic [2:0] F3_XOR    = 3'd4;
    localparam logic [2:0] F3_SR     = 3'd5;
    localparam logic [2:0] F3_OR     = 3'd6;
    localparam logic [2:0] F3_AND    = 3'd7;
    localparam logic [2:0] F3_BEQ    = 3'd0;
    localparam logic [2:0] F3_BNE    = 3'd1;
    localparam logic [2:0] F3_BLT    = 3'd4;
    localparam logic [2:0] F3_BGE    = 3'd5;
    localparam logic [2:0] F3_BLTU   = 3'd6;
    localparam logic [2:0] F3_BGEU   = 3'd7;

    typedef logic [5:0] op_t;

    // Decoded operation codes
    localparam op_t OP_LUI   = 6'd0;
    localparam op_t OP_AUIPC = 6'd1;
    localparam op_t OP_JAL   = 6'd2;
    localparam op_t OP_JALR  = 6'd3;
    localparam op_t OP_LB    = 6'd4;
    localparam op_t OP_LH    = 6'd5;
    localparam op_t OP_LW    = 6'd6;
    localparam op_t OP_LBU   = 6'd7;
    localparam op_t OP_LHU   = 6'd8;
    localparam op_t OP_ADDI  = 6'd9;
    localparam op_t OP_SLTI  = 6'd10;
    localparam op_t OP_SLTIU = 6'd11;
    localparam op_t OP_XORI  = 6'd12;
    localparam op_t OP_ORI   = 6'd13;
    localparam op_t OP_ANDI  = 6'd14;
    localparam op_t OP_SLLI  = 6'd15;
    localparam op_t OP_SRLI  = 6'd16;
    localparam op_t OP_SRAI  = 6'd17;
    localparam op_t OP_BEQ   = 6'd18;
    localparam op_t OP_BNE   = 6'd19;
    localparam op_t OP_BLT   = 6'd20;
    localparam op_t OP_BGE   = 6'd21;
    localparam op_t OP_BLTU  = 6'd22;
    localparam op_t OP_BGEU  = 6'd23;
    localparam op_t OP_SB    = 6'd24;
    localparam op_t OP_SH    = 6'd25;
    localparam op_t OP_SW    = 6'd26;
    localparam op_t OP_ADD   = 6'd27;
    localparam op_t OP_SUB   = 6'd28;
    localparam op_t OP_SLL   = 6'd29;
    localparam op_t OP_SLT   = 6'd30;
    localparam op_t OP_SLTU  = 6'd31;
    localparam op_t OP_XOR   = 6'd32;
    localparam op_t OP_SRL   = 6'd33;
    localparam op_t OP_SRA   = 6'd34;
    localparam op_t OP_OR    = 6'd35;
    localparam op_t OP_AND   = 6'd36;

    // Decoded item travelling from front to back
    typedef struct packed {
        op_t         op;
        logic        illegal;
        logic        halt;
        logic [4:0]  dest_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic [31:0] imm;
        logic [31:0] pc;
        logic [31:0] src1_value;
        logic [31:0] src2_value;
    } dec_item_t;

    // Result item held in the output register
    typedef struct packed {
        op_t         op;
        logic [4:0]  dest_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic [31:0] imm;
        logic [31:0] result;
        logic        taken;
        logic [31:0] target;
        logic [31:0] mem_addr;
        logic        illegal;
        logic        halt;
    } exe_item_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

/* design/rv32i_decode_execute.sv */
// Top level of the RV32I decode and execute block: front, queue and back.
//
//  channel | dir | tdata                                  | tuser
//  s_      | in  | instruction word, pc, rs1 value, rs2   | -
//  m_      | out | decoded fields and execute results     | illegal, halt
//
// One item per cycle sustained while m_tready stays high; an accepted item passes
// through the decode queue and then the output register before it reaches m_tvalid.
// The front decodes into a two-entry queue, the back runs the ALU into the
// output register. s_tready drops only when the queue is full.
// aresetn is synchronous and empties the queue and the output register.
`default_nettype none

module rv32i_decode_execute (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // instr_word, instr_pc, src1_value, src2_value
    input  wire logic [rvde_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // operation, dest_reg, src1_reg, src2_reg, immediate, result_value,
    // taken, target_address, mem_address, zero fill
    output logic [rvde_pkg::M_TDATA_W-1:0]         m_tdata,
    // illegal, halt
    output logic [rvde_pkg::M_TUSER_W-1:0]         m_tuser
);
    import rvde_pkg::*;

    q_status_t q_status;
    dec_item_t dec_item;
    dec_item_t head_item;
    exe_item_t m_item;
    logic      push;
    logic      pop;

    rvde_decode u_decode (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .push     (push),
        .item     (dec_item)
    );

    rvde_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (dec_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    rvde_execute u_execute (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .head_item (head_item),
        .pop       (pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_item    (m_item)
    );

    // Pack the result item
    assign m_tdata = {2'b00, m_item.mem_addr, m_item.target, m_item.taken,
                      m_item.result, m_item.imm, m_item.src2_reg,
                      m_item.src1_reg, m_item.dest_reg, m_item.op};
    assign m_tuser = {m_item.halt, m_item.illegal};

    // An item accepted into an empty block goes through the queue into the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !q_status.valid && !m_tvalid) |-> ##2 m_tvalid)
        else $error("accepted item did not reach the output in two cycles");

    // The halt word is a legal ADDI
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && m_tdata[5:0] == OP_ADDI))
        else $error("halt item not decoded as ADDI");

    // An illegal item carries no operation, immediate or results
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[5:0] == OP_LUI && m_tdata[52:21] == 32'd0 && !m_tdata[85]
             && m_tdata[149:86] == 64'd0))
        else $error("illegal item carries results");

    // Only jumps and branches are taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[85]) |->
            (m_tdata[5:0] == OP_JAL || m_tdata[5:0] == OP_JALR
             || (m_tdata[5:0] >= OP_BEQ && m_tdata[5:0] <= OP_BGEU)))
        else $error("taken set on a non-control item");

endmodule

`default_nettype wire

/* design/rvde_decode.sv */
// Front part: accepts instruction items and classifies them into decoded items.
`default_nettype none

module rvde_decode (
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [rvde_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire rvde_pkg::q_status_t               q_status,
    output logic                                   push,
    output rvde_pkg::dec_item_t                    item
);
    import rvde_pkg::*;

    logic [31:0] word;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic [31:0] imm_sh;
    logic        bad;
    op_t         op;
    logic [31:0] imm;

    // Take an item whenever the queue has room
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    assign word = s_tdata[31:0];
    assign opc  = word[6:0];
    assign f3   = word[14:12];
    assign f7   = word[31:25];

    // Immediates of every format
    assign imm_i  = {{20{word[31]}}, word[31:20]};
    assign imm_s  = {{20{word[31]}}, word[31:25], word[11:7]};
    assign imm_b  = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    assign imm_u  = {word[31:12], 12'b0};
    assign imm_j  = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
    assign imm_sh = {27'b0, word[24:20]};

    // Classify opcode, funct3 and funct7
    always_comb begin
        op  = OP_LUI;
        imm = '0;
        bad = 1'b0;
        case (opc)
            OPC_LUI: begin
                op  = OP_LUI;
                imm = imm_u;
            end
            OPC_AUIPC: begin
                op  = OP_AUIPC;
                imm = imm_u;
            end
            OPC_JAL: begin
                op  = OP_JAL;
                imm = imm_j;
            end
            OPC_JALR: begin
                op  = OP_JALR;
                imm = imm_i;
                bad = (f3 != F3_JALR);
            end
            OPC_LOAD: begin
                imm = imm_i;
                case (f3)
                    F3_BYTE:   op = OP_LB;
                    F3_HALF:   op = OP_LH;
                    F3_WORD:   op = OP_LW;
                    F3_BYTE_U: op = OP_LBU;
                    F3_HALF_U: op = OP_LHU;
                    default:   bad = 1'b1;
                endcase
            end
            OPC_OPIMM: begin
                imm = imm_i;
                case (f3)
                    F3_ADD:  op = OP_ADDI;
                    F3_SLT:  op = OP_SLTI;
                    F3_SLTU: op = OP_SLTIU;
                    F3_XOR:  op = OP_XORI;
                    F3_OR:   op = OP_ORI;
                    F3_AND:  op = OP_ANDI;
                    F3_SLL: begin
                        imm = imm_sh;
                        op  = OP_SLLI;
                        bad = (f7 != F7_BASE);
                    end
                    default: begin
                        imm = imm_sh;
                        if (f7 == F7_BASE) begin
                            op = OP_SRLI;
                        end else if (f7 == F7_ALT) begin
                            op = OP_SRAI;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                endcase
            end
            OPC_BRANCH: begin
                imm = imm_b;
                case (f3)
                    F3_BEQ:  op = OP_BEQ;
                    F3_BNE:  op = OP_BNE;
                    F3_BLT:  op = OP_BLT;
                    F3_BGE:  op = OP_BGE;
                    F3_BLTU: op = OP_BLTU;
                    F3_BGEU: op = OP_BGEU;
                    default: bad = 1'b1;
                endcase
            end
            OPC_STORE: begin
                imm = imm_s;
                case (f3)
                    F3_BYTE: op = OP_SB;
                    F3_HALF: op = OP_SH;
                    F3_WORD: op = OP_SW;
                    default: bad = 1'b1;
                endcase
            end
            OPC_OP: begin
                if (f7 == F7_ALT) begin
                    if (f3 == F3_ADD) begin
                        op = OP_SUB;
                    end else if (f3 == F3_SR) begin
                        op = OP_SRA;
                    end else begin
                        bad = 1'b1;
                    end
                end else if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD:  op = OP_ADD;
                        F3_SLL:  op = OP_SLL;
                        F3_SLT:  op = OP_SLT;
                        F3_SLTU: op = OP_SLTU;
                        F3_XOR:  op = OP_XOR;
                        F3_SR:   op = OP_SRL;
                        F3_OR:   op = OP_OR;
                        default: op = OP_AND;
                    endcase
                end else begin
                    bad = 1'b1;
                end
            end
            default: bad = 1'b1;
        endcase
    end

    // Build the decoded item; an illegal word carries no operation or immediate
    always_comb begin
        item.op         = bad ? OP_LUI : op;
        item.illegal    = bad;
        item.halt       = (word == HALT_WORD);
        item.dest_reg   = word[11:7];
        item.src1_reg   = word[19:15];
        item.src2_reg   = word[24:20];
        item.imm        = bad ? 32'd0 : imm;
        item.pc         = s_tdata[63:32];
        item.src1_value = s_tdata[95:64];
        item.src2_value = s_tdata[127:96];
    end

endmodule

`default_nettype wire

/* design/rvde_queue.sv */
// Short queue of decoded items between the front and back parts.
`default_nettype none

module rvde_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire rvde_pkg::dec_item_t   push_item,
    input  wire logic                  pop,
    output rvde_pkg::dec_item_t        head_item,
    output rvde_pkg::q_status_t        status
);
    import rvde_pkg::*;

    dec_item_t         entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign head_item    = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming item
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* design/rvde_execute.sv */
// Back part: carries out decoded items and holds results in the output register.
`default_nettype none

module rvde_execute (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire rvde_pkg::q_status_t   q_status,
    input  wire rvde_pkg::dec_item_t   head_item,
    output logic                       pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output rvde_pkg::exe_item_t        m_item
);
    import rvde_pkg::*;

    logic        out_valid_reg;
    logic        out_valid_next;
    exe_item_t   out_item_reg;
    exe_item_t   res;

    logic [31:0] a;
    logic [31:0] opnd2;
    logic [4:0]  shamt;
    logic [31:0] sum;
    logic [31:0] diff;
    logic [31:0] pc_imm;
    logic [31:0] link;
    logic        lt_s;
    logic        lt_u;
    logic        eq;
    logic [31:0] alu;
    logic        cond;
    logic        use_src2;

    // Move the head item on when the output register is free or being emptied
    assign pop     = q_status.valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // Shared operands: register operand for R-type and branches, else immediate
    assign a        = head_item.src1_value;
    assign use_src2 = (head_item.op inside {[OP_BEQ:OP_BGEU], [OP_ADD:OP_AND]});
    assign opnd2    = use_src2 ? head_item.src2_value : head_item.imm;
    assign shamt    = opnd2[4:0];
    assign sum      = a + opnd2;
    assign diff     = a - opnd2;
    assign pc_imm   = head_item.pc + head_item.imm;
    assign link     = head_item.pc + 32'd4;
    assign lt_s     = ($signed(a) < $signed(opnd2));
    assign lt_u     = (a < opnd2);
    assign eq       = (a == opnd2);

    // Arithmetic, logic and shift result
    always_comb begin
        case (head_item.op)
            OP_ADDI, OP_ADD:    alu = sum;
            OP_SUB:             alu = diff;
            OP_SLTI, OP_SLT:    alu = {31'b0, lt_s};
            OP_SLTIU, OP_SLTU:  alu = {31'b0, lt_u};
            OP_XORI, OP_XOR:    alu = a ^ opnd2;
            OP_ORI, OP_OR:      alu = a | opnd2;
            OP_ANDI, OP_AND:    alu = a & opnd2;
            OP_SLLI, OP_SLL:    alu = a << shamt;
            OP_SRLI, OP_SRL:    alu = a >> shamt;
            OP_SRAI, OP_SRA:    alu = 32'($signed(a) >>> shamt);
            default:            alu = '0;
        endcase
    end

    // Branch condition
    always_comb begin
        case (head_item.op)
            OP_BEQ:  cond = eq;
            OP_BNE:  cond = !eq;
            OP_BLT:  cond = lt_s;
            OP_BGE:  cond = !lt_s;
            OP_BLTU: cond = lt_u;
            OP_BGEU: cond = !lt_u;
            default: cond = 1'b0;
        endcase
    end

    // Assemble the result item
    always_comb begin
        res.op       = head_item.op;
        res.dest_reg = head_item.dest_reg;
        res.src1_reg = head_item.src1_reg;
        res.src2_reg = head_item.src2_reg;
        res.imm      = head_item.imm;
        res.illegal  = head_item.illegal;
        res.halt     = head_item.halt;
        res.result   = '0;
        res.taken    = 1'b0;
        res.target   = '0;
        res.mem_addr = '0;
        if (!head_item.illegal) begin
            case (head_item.op)
                OP_LUI:   res.result = head_item.imm;
                OP_AUIPC: res.result = pc_imm;
                OP_JAL: begin
                    res.result = link;
                    res.taken  = 1'b1;
                    res.target = pc_imm;
                end
                OP_JALR: begin
                    res.result = link;
                    res.taken  = 1'b1;
                    res.target = {sum[31:1], 1'b0};
                end
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: begin
                    res.mem_addr = sum;
                end
                OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
                    res.result = {31'b0, cond};
                    res.taken  = cond;
                    res.target = pc_imm;
                end
                default:  res.result = alu;
            endcase
        end
    end

    // Hold the result until the item is taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_item_reg <= res;
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for rv32i_decode_execute: directed table, then random instructions.
`default_nettype none

module tb_top;
    import rvde_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 60;
    localparam int HOLD_AT      = 350;

    typedef struct packed {
        op_t         op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [31:0] res;
        logic        taken;
        logic [31:0] tgt;
        logic [31:0] maddr;
        logic        illegal;
        logic        halt;
    } exec_result_t;

    typedef struct {
        logic [31:0]  word;
        logic [31:0]  pc;
        logic [31:0]  a;
        logic [31:0]  b;
        logic         typed;
        exec_result_t want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    exec_result_t pending_results[$];
    stim_row_t    dir_tab[$];
    int unsigned  mismatch_count = 0;
    int unsigned  results_seen = 0;
    int unsigned  cycle_count = 0;
    logic         idle_on = 1'b1;
    logic         hold_done = 1'b0;
    exec_result_t got_result;
    exec_result_t due_result;

    rv32i_decode_execute DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Instruction encoders
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] opc);
        return {imm, rd, opc};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    // Decode and execute one instruction
    function automatic exec_result_t predict_exec(logic [31:0] w, logic [31:0] pc,
                                                  logic [31:0] a, logic [31:0] b);
        exec_result_t r;
        logic [6:0]   opc;
        logic [6:0]   f7;
        logic [2:0]   f3;
        logic [31:0]  imm_i;
        logic [4:0]   sh;
        logic         cond;
        logic         bad;
        r     = '0;
        opc   = w[6:0];
        f3    = w[14:12];
        f7    = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        cond  = 1'b0;
        bad   = 1'b0;
        case (opc)
            OPC_LUI: begin
                r.op  = OP_LUI;
                r.imm = {w[31:12], 12'b0};
                r.res = r.imm;
            end
            OPC_AUIPC: begin
                r.op  = OP_AUIPC;
                r.imm = {w[31:12], 12'b0};
                r.res = pc + r.imm;
            end
            OPC_JAL: begin
                r.op    = OP_JAL;
                r.imm   = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
                r.res   = pc + 32'd4;
                r.taken = 1'b1;
                r.tgt   = pc + r.imm;
            end
            OPC_JALR: begin
                if (f3 != F3_JALR) begin
                    bad = 1'b1;
                end else begin
                    r.op    = OP_JALR;
                    r.imm   = imm_i;
                    r.res   = pc + 32'd4;
                    r.taken = 1'b1;
                    r.tgt   = (a + imm_i) & ~32'd1;
                end
            end
            OPC_LOAD: begin
                r.imm   = imm_i;
                r.maddr = a + imm_i;
                case (f3)
                    F3_BYTE:   r.op = OP_LB;
                    F3_HALF:   r.op = OP_LH;
                    F3_WORD:   r.op = OP_LW;
                    F3_BYTE_U: r.op = OP_LBU;
                    F3_HALF_U: r.op = OP_LHU;
                    default:   bad = 1'b1;
                endcase
            end
            OPC_OPIMM: begin
                if (f3 == F3_SLL || f3 == F3_SR) begin
                    sh    = w[24:20];
                    r.imm = {27'b0, sh};
                    if (f3 == F3_SLL && f7 == F7_BASE) begin
                        r.op  = OP_SLLI;
                        r.res = a << sh;
                    end else if (f3 == F3_SR && f7 == F7_BASE) begin
                        r.op  = OP_SRLI;
                        r.res = a >> sh;
                    end else if (f3 == F3_SR && f7 == F7_ALT) begin
                        r.op  = OP_SRAI;
                        r.res = $signed(a) >>> sh;
                    end else begin
                        bad = 1'b1;
                    end
                end else begin
                    r.imm = imm_i;
                    case (f3)
                        F3_ADD:  begin r.op = OP_ADDI;  r.res = a + imm_i; end
                        F3_SLT:  begin
                            r.op  = OP_SLTI;
                            r.res = {31'b0, $signed(a) < $signed(imm_i)};
                        end
                        F3_SLTU: begin r.op = OP_SLTIU; r.res = {31'b0, a < imm_i}; end
                        F3_XOR:  begin r.op = OP_XORI;  r.res = a ^ imm_i; end
                        F3_OR:   begin r.op = OP_ORI;   r.res = a | imm_i; end
                        default: begin r.op = OP_ANDI;  r.res = a & imm_i; end
                    endcase
                end
            end
            OPC_BRANCH: begin
                r.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
                r.tgt = pc + r.imm;
                case (f3)
                    F3_BEQ:  begin r.op = OP_BEQ;  cond = (a == b); end
                    F3_BNE:  begin r.op = OP_BNE;  cond = (a != b); end
                    F3_BLT:  begin r.op = OP_BLT;  cond = ($signed(a) < $signed(b)); end
                    F3_BGE:  begin r.op = OP_BGE;  cond = ($signed(a) >= $signed(b)); end
                    F3_BLTU: begin r.op = OP_BLTU; cond = (a < b); end
                    F3_BGEU: begin r.op = OP_BGEU; cond = (a >= b); end
                    default: bad = 1'b1;
                endcase
                r.res   = {31'b0, cond};
                r.taken = cond;
            end
            OPC_STORE: begin
                r.imm   = {{20{w[31]}}, w[31:25], w[11:7]};
                r.maddr = a + r.imm;
                case (f3)
                    F3_BYTE: r.op = OP_SB;
                    F3_HALF: r.op = OP_SH;
                    F3_WORD: r.op = OP_SW;
                    default: bad = 1'b1;
                endcase
            end
            OPC_OP: begin
                sh = b[4:0];
                if (f7 == F7_ALT) begin
                    case (f3)
                        F3_ADD:  begin r.op = OP_SUB; r.res = a - b; end
                        F3_SR:   begin r.op = OP_SRA; r.res = $signed(a) >>> sh; end
                        default: bad = 1'b1;
                    endcase
                end else if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD:  begin r.op = OP_ADD;  r.res = a + b; end
                        F3_SLL:  begin r.op = OP_SLL;  r.res = a << sh; end
                        F3_SLT:  begin
                            r.op  = OP_SLT;
                            r.res = {31'b0, $signed(a) < $signed(b)};
                        end
                        F3_SLTU: begin r.op = OP_SLTU; r.res = {31'b0, a < b}; end
                        F3_XOR:  begin r.op = OP_XOR;  r.res = a ^ b; end
                        F3_SR:   begin r.op = OP_SRL;  r.res = a >> sh; end
                        F3_OR:   begin r.op = OP_OR;   r.res = a | b; end
                        default: begin r.op = OP_AND;  r.res = a & b; end
                    endcase
                end else begin
                    bad = 1'b1;
                end
            end
            default: bad = 1'b1;
        endcase
        // An unknown encoding keeps only the register fields
        if (bad) begin
            r = '0;
            r.illegal = 1'b1;
        end
        r.rd   = w[11:7];
        r.rs1  = w[19:15];
        r.rs2  = w[24:20];
        r.halt = (w == HALT_WORD);
        return r;
    endfunction

    // Build a well-formed word for the given operation with random fields
    function automatic logic [31:0] compose_word(op_t op);
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] rnd;
        rd  = 5'($urandom());
        rs1 = 5'($urandom());
        rs2 = 5'($urandom());
        rnd = $urandom();
        case (op)
            OP_LUI:   return enc_u(rnd[19:0], rd, OPC_LUI);
            OP_AUIPC: return enc_u(rnd[19:0], rd, OPC_AUIPC);
            OP_JAL:   return enc_j({rnd[20:1], 1'b0}, rd);
            OP_JALR:  return enc_i(rnd[11:0], rs1, F3_JALR, rd, OPC_JALR);
            OP_LB:    return enc_i(rnd[11:0], rs1, F3_BYTE, rd, OPC_LOAD);
            OP_LH:    return enc_i(rnd[11:0], rs1, F3_HALF, rd, OPC_LOAD);
            OP_LW:    return enc_i(rnd[11:0], rs1, F3_WORD, rd, OPC_LOAD);
            OP_LBU:   return enc_i(rnd[11:0], rs1, F3_BYTE_U, rd, OPC_LOAD);
            OP_LHU:   return enc_i(rnd[11:0], rs1, F3_HALF_U, rd, OPC_LOAD);
            OP_ADDI:  return enc_i(rnd[11:0], rs1, F3_ADD, rd, OPC_OPIMM);
            OP_SLTI:  return enc_i(rnd[11:0], rs1, F3_SLT, rd, OPC_OPIMM);
            OP_SLTIU: return enc_i(rnd[11:0], rs1, F3_SLTU, rd, OPC_OPIMM);
            OP_XORI:  return enc_i(rnd[11:0], rs1, F3_XOR, rd, OPC_OPIMM);
            OP_ORI:   return enc_i(rnd[11:0], rs1, F3_OR, rd, OPC_OPIMM);
            OP_ANDI:  return enc_i(rnd[11:0], rs1, F3_AND, rd, OPC_OPIMM);
            OP_SLLI:  return enc_r(F7_BASE, rs2, rs1, F3_SLL, rd, OPC_OPIMM);
            OP_SRLI:  return enc_r(F7_BASE, rs2, rs1, F3_SR, rd, OPC_OPIMM);
            OP_SRAI:  return enc_r(F7_ALT, rs2, rs1, F3_SR, rd, OPC_OPIMM);
            OP_BEQ:   return enc_b(rnd[12:0], rs2, rs1, F3_BEQ);
            OP_BNE:   return enc_b(rnd[12:0], rs2, rs1, F3_BNE);
            OP_BLT:   return enc_b(rnd[12:0], rs2, rs1, F3_BLT);
            OP_BGE:   return enc_b(rnd[12:0], rs2, rs1, F3_BGE);
            OP_BLTU:  return enc_b(rnd[12:0], rs2, rs1, F3_BLTU);
            OP_BGEU:  return enc_b(rnd[12:0], rs2, rs1, F3_BGEU);
            OP_SB:    return enc_s(rnd[11:0], rs2, rs1, F3_BYTE);
            OP_SH:    return enc_s(rnd[11:0], rs2, rs1, F3_HALF);
            OP_SW:    return enc_s(rnd[11:0], rs2, rs1, F3_WORD);
            OP_ADD:   return enc_r(F7_BASE, rs2, rs1, F3_ADD, rd, OPC_OP);
            OP_SUB:   return enc_r(F7_ALT, rs2, rs1, F3_ADD, rd, OPC_OP);
            OP_SLL:   return enc_r(F7_BASE, rs2, rs1, F3_SLL, rd, OPC_OP);
            OP_SLT:   return enc_r(F7_BASE, rs2, rs1, F3_SLT, rd, OPC_OP);
            OP_SLTU:  return enc_r(F7_BASE, rs2, rs1, F3_SLTU, rd, OPC_OP);
            OP_XOR:   return enc_r(F7_BASE, rs2, rs1, F3_XOR, rd, OPC_OP);
            OP_SRL:   return enc_r(F7_BASE, rs2, rs1, F3_SR, rd, OPC_OP);
            OP_SRA:   return enc_r(F7_ALT, rs2, rs1, F3_SR, rd, OPC_OP);
            OP_OR:    return enc_r(F7_BASE, rs2, rs1, F3_OR, rd, OPC_OP);
            OP_AND:   return enc_r(F7_BASE, rs2, rs1, F3_AND, rd, OPC_OP);
            default:  return rnd;
        endcase
    endfunction

    // Favour the corner values of a 32-bit operand
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'h7fff_ffff;
            3:       return 32'h8000_0000;
            4:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic stim_row_t row_of(logic [31:0] w, logic [31:0] pc,
                                         logic [31:0] a, logic [31:0] b);
        stim_row_t row;
        row.word  = w;
        row.pc    = pc;
        row.a     = a;
        row.b     = b;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(stim_row_t row);
        dir_tab.insert(dir_tab.size(), row);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Offer one item, hold until accepted, then queue its expectation
    task automatic send_item(logic [31:0] w, logic [31:0] pc, logic [31:0] a,
                             logic [31:0] b, exec_result_t want);
        while (idle_on && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a, pc, w};
        do @(posedge aclk); while (!s_tready);
        pending_results.insert(pending_results.size(), want);
    endtask

    // Stimulus: directed table, then random instructions, then drain
    initial begin
        stim_row_t   row;
        logic [31:0] word;
        logic [31:0] pc;
        logic [31:0] a;
        logic [31:0] b;
        int unsigned kind;

        // Halt marker straight after reset
        row = row_of(HALT_WORD, 32'h0, 32'h0, 32'h0);
        row.typed        = 1'b1;
        row.want.op      = OP_ADDI;
        row.want.rd      = 5'd10;
        row.want.rs2     = 5'd31;
        row.want.imm     = 32'd255;
        row.want.res     = 32'd255;
        row.want.halt    = 1'b1;
        add_row(row);
        // All-ones and all-zero words are unknown opcodes
        row = row_of(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        row.typed        = 1'b1;
        row.want.rd      = 5'd31;
        row.want.rs1     = 5'd31;
        row.want.rs2     = 5'd31;
        row.want.illegal = 1'b1;
        add_row(row);
        row = row_of(32'h0, 32'h0, 32'h0, 32'h0);
        row.typed        = 1'b1;
        row.want.illegal = 1'b1;
        add_row(row);
        row = row_of(enc_u(20'hfffff, 5'd31, OPC_LUI), 32'h0, 32'h0, 32'h0);
        row.typed        = 1'b1;
        row.want.op      = OP_LUI;
        row.want.rd      = 5'd31;
        row.want.rs1     = 5'd31;
        row.want.rs2     = 5'd31;
        row.want.imm     = 32'hffff_f000;
        row.want.res     = 32'hffff_f000;
        add_row(row);
        // Extremes of immediates and operands, plus the rejected encodings
        add_row(row_of(enc_u(20'h80000, 5'd1, OPC_AUIPC), 32'hffff_ffff, 0, 0));
        add_row(row_of(enc_j(21'h100000, 5'd1), 32'h0, 0, 0));
        add_row(row_of(enc_j(21'h0ffffe, 5'd0), 32'hffff_fffc, 0, 0));
        add_row(row_of(enc_i(12'h7ff, 5'd2, F3_JALR, 5'd1, OPC_JALR),
                       32'h100, 32'h2, 0));
        add_row(row_of(enc_i(12'h001, 5'd1, 3'd1, 5'd1, OPC_JALR), 32'h0, 0, 0));
        add_row(row_of(enc_i(12'h800, 5'd3, F3_BYTE, 5'd4, OPC_LOAD), 0, 0, 0));
        add_row(row_of(enc_i(12'h7ff, 5'd3, F3_HALF_U, 5'd4, OPC_LOAD),
                       0, 32'hffff_ffff, 0));
        add_row(row_of(enc_i(12'h0, 5'd3, 3'd3, 5'd4, OPC_LOAD), 0, 0, 0));
        add_row(row_of(enc_i(12'h7ff, 5'd5, F3_SLT, 5'd6, OPC_OPIMM),
                       0, 32'h8000_0000, 0));
        add_row(row_of(enc_i(12'hfff, 5'd5, F3_SLTU, 5'd6, OPC_OPIMM), 0, 1, 0));
        add_row(row_of(enc_r(F7_BASE, 5'd31, 5'd7, F3_SLL, 5'd8, OPC_OPIMM),
                       0, 1, 0));
        add_row(row_of(enc_r(7'h01, 5'd3, 5'd7, F3_SLL, 5'd8, OPC_OPIMM), 0, 1, 0));
        add_row(row_of(enc_r(F7_ALT, 5'd31, 5'd7, F3_SR, 5'd8, OPC_OPIMM),
                       0, 32'h8000_0000, 0));
        add_row(row_of(enc_r(F7_BASE, 5'd0, 5'd7, F3_SR, 5'd8, OPC_OPIMM),
                       0, 32'hffff_ffff, 0));
        add_row(row_of(enc_b(13'h1000, 5'd9, 5'd9, F3_BEQ), 32'h0, 32'h5, 32'h5));
        add_row(row_of(enc_b(13'h0ffe, 5'd9, 5'd10, F3_BLT), 32'h1000,
                       32'h8000_0000, 32'h7fff_ffff));
        add_row(row_of(enc_b(13'h0004, 5'd9, 5'd10, F3_BGEU), 32'h40,
                       32'h0, 32'hffff_ffff));
        add_row(row_of(enc_s(12'h800, 5'd11, 5'd12, F3_WORD), 0, 0, 32'h1234));
        add_row(row_of(enc_s(12'h0, 5'd11, 5'd12, 3'd3), 0, 0, 0));
        add_row(row_of(enc_r(F7_ALT, 5'd13, 5'd14, F3_ADD, 5'd15, OPC_OP), 0, 0, 1));
        add_row(row_of(enc_r(F7_ALT, 5'd13, 5'd14, F3_SR, 5'd15, OPC_OP),
                       0, 32'h8000_0000, 32'hffff_ffff));
        add_row(row_of(enc_r(7'h01, 5'd13, 5'd14, F3_ADD, 5'd15, OPC_OP), 0, 3, 4));

        // Hold reset, then release
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            send_item(row.word, row.pc, row.a, row.b,
                      row.typed ? row.want : predict_exec(row.word, row.pc, row.a, row.b));
        end

        // Random part: mostly well-formed, some broken function fields, some noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = !(n >= 300 && n < 600);
            kind = $urandom_range(99);
            if (kind < 2)
                word = HALT_WORD;
            else if (kind < 80)
                word = compose_word(op_t'($urandom_range(36)));
            else if (kind < 92)
                word = compose_word(op_t'($urandom_range(36))) ^ ($urandom() & 32'hfe00_7000);
            else
                word = $urandom();
            pc = pick_operand();
            a  = pick_operand();
            b  = ($urandom_range(7) == 0) ? a : pick_operand();
            send_item(word, pc, a, b, predict_exec(word, pc, a, b));
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b1;

        // Drain the expectations, then allow for the pipeline
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("rv32i_decode_execute verification clean");
        end else begin
            $display("rv32i_decode_execute verification failed");
        end
        $finish;
    end

    // Result side: random back-pressure and one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= !(idle_on && $urandom_range(99) < 32);
        end
    end

    // Compare each delivered item with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result.op      = m_tdata[5:0];
            got_result.rd      = m_tdata[10:6];
            got_result.rs1     = m_tdata[15:11];
            got_result.rs2     = m_tdata[20:16];
            got_result.imm     = m_tdata[52:21];
            got_result.res     = m_tdata[84:53];
            got_result.taken   = m_tdata[85];
            got_result.tgt     = m_tdata[117:86];
            got_result.maddr   = m_tdata[149:118];
            got_result.illegal = m_tuser[0];
            got_result.halt    = m_tuser[1];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item: expected none, got %h", $time, got_result);
                mismatch_count++;
            end else begin
                due_result = pending_results.pop_front();
                check_field("operation", 32'(due_result.op), 32'(got_result.op));
                check_field("dest_reg", 32'(due_result.rd), 32'(got_result.rd));
                check_field("src1_reg", 32'(due_result.rs1), 32'(got_result.rs1));
                check_field("src2_reg", 32'(due_result.rs2), 32'(got_result.rs2));
                check_field("immediate", due_result.imm, got_result.imm);
                check_field("result_value", due_result.res, got_result.res);
                check_field("taken", 32'(due_result.taken), 32'(got_result.taken));
                check_field("target_address", due_result.tgt, got_result.tgt);
                check_field("mem_address", due_result.maddr, got_result.maddr);
                check_field("illegal", 32'(due_result.illegal), 32'(got_result.illegal));
                check_field("halt", 32'(due_result.halt), 32'(got_result.halt));
            end
            results_seen++;
        end
    end

    // Stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("rv32i_decode_execute verification failed");
        $finish;
    end

endmodule

`default_nettype wire

/* rv32i_decode_execute.f */
design/rvde_pkg.sv
design/rvde_decode.sv
design/rvde_queue.sv
design/rvde_execute.sv
design/rv32i_decode_execute.sv
tb/sv/tb_top.sv
